// File: rtl/core/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types, field widths, request codes and constant tables for the
// polyphonic voice allocator with per-voice envelope.
// ----------------------------------------------------------------------------
package pva_pkg;

  // Defaults for the top-level parameters
  localparam int VOICE_SLOTS_DEF    = 16;
  localparam int FREQ_FRAC_BITS_DEF = 8;

  // Fixed field widths
  localparam int REQ_W       = 3;
  localparam int NOTE_W      = 7;
  localparam int VEL_W       = 7;
  localparam int CHAN_W      = 4;
  localparam int GAIN_W      = 16;
  localparam int AMP_W       = 16;
  localparam int CFG_W       = 15;
  localparam int CFG_IDX_W   = 4;
  localparam int IDX_OUT_W   = 4;
  localparam int FREQ_OUT_W  = 24;
  localparam int COUNT_OUT_W = 5;
  localparam int FREQ_INT_W  = 16;
  localparam int NOTES       = 128;

  // Fixed-point constants
  localparam int GAIN_FRAC  = 14;
  localparam int AMP_FRAC   = 15;
  localparam int SNAP_LIMIT = 33;

  // Register reset values
  localparam logic [CFG_W-1:0] ATTACK_RST  = 15'd3277;
  localparam logic [CFG_W-1:0] DECAY_RST   = 15'd3277;
  localparam logic [CFG_W-1:0] SUSTAIN_RST = 15'd22938;
  localparam logic [CFG_W-1:0] RELEASE_RST = 15'd6554;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Request codes on the input word
  typedef enum logic [REQ_W-1:0] {
    REQ_NOTE_ON   = 3'd0,
    REQ_NOTE_OFF  = 3'd1,
    REQ_BEND      = 3'd2,
    REQ_RESET_ALL = 3'd3,
    REQ_TICK      = 3'd4
  } req_t;

  // Classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_BEND,
    OP_CLEAR,
    OP_TICK,
    OP_NONE
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 4'd0,
    CFG_DECAY   = 4'd1,
    CFG_SUSTAIN = 4'd2,
    CFG_RELEASE = 4'd3
  } cfg_idx_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_CALC,
    B_WR,
    B_OUT
  } bstate_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [NOTE_W-1:0] note_number;
    logic [VEL_W-1:0]  note_velocity;
    logic [CHAN_W-1:0] midi_channel;
    logic [GAIN_W-1:0] bend_gain;
  } in_item_t;

  typedef struct packed {
    logic                   hit;
    logic [IDX_OUT_W-1:0]   slot_index;
    logic [FREQ_OUT_W-1:0]  slot_freq;
    logic [COUNT_OUT_W-1:0] active_count;
    logic                   any_active;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     value;
  } cfg_item_t;

  typedef struct packed {
    op_t               op;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [CHAN_W-1:0] chan;
    logic [GAIN_W-1:0] gain;
  } cmd_t;

  // Notes 120..131 in Q16.16 Hz
  localparam logic [31:0] TOP_OCTAVE [12] = '{
    32'd548668578, 32'd581294109, 32'd615859672, 32'd652480576,
    32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
    32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748354
  };

  typedef logic [31:0]      freq_tab_t  [NOTES];
  typedef logic [AMP_W-1:0] level_tab_t [NOTES];

  // Equal-tempered pitch per note, Q16.frac, rounded half up
  function automatic freq_tab_t build_freq_tab(int frac);
    freq_tab_t       tab;
    longint unsigned v;
    int              sh;
    for (int n = 0; n < NOTES; n++) begin
      sh = (10 - n / 12) + (16 - frac);
      v  = longint'(TOP_OCTAVE[n % 12]);
      if (sh > 0) begin
        v = (v + (64'd1 << (sh - 1))) >> sh;
      end
      tab[n] = v[31:0];
    end
    return tab;
  endfunction

  // Velocity level in Q1.15, 127 gives 1.0
  function automatic level_tab_t build_level_tab();
    level_tab_t tab;
    int         lv;
    for (int v = 0; v < NOTES; v++) begin
      lv     = (v * 32768 + 63) / 127;
      tab[v] = lv[AMP_W-1:0];
    end
    return tab;
  endfunction

endpackage

// File: rtl/core/pva_if.sv
// ----------------------------------------------------------------------------
// pva_if
// Valid/ready channels of the voice allocator: request, result and
// configuration write.
// ----------------------------------------------------------------------------
interface pva_in_if;
  logic               valid;
  logic               ready;
  pva_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pva_out_if;
  logic               valid;
  logic               ready;
  pva_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pva_cfg_if;
  logic               valid;
  logic               ready;
  pva_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/poly_voice_allocator_envelope_top.sv
// ----------------------------------------------------------------------------
// poly_voice_allocator_envelope_top
// Polyphonic voice allocator with a per-voice attack/decay/release envelope.
// ----------------------------------------------------------------------------
// Each request word (note-on, note-off, pitch bend, reset-all, envelope tick)
// returns exactly one result word. Requests pass through a two-word queue to a
// back end that handles one request at a time, walking the slot table held in
// a single RAM. Reset-all and unused codes go straight to the result; note-on
// tests one activity bit per cycle until it finds a free slot; note-off reads
// and compares each slot in turn; pitch bend and envelope tick read each slot
// from the slot RAM, multiply and write it back (bend only on its channel).
// Configuration writes are taken at any time, one per cycle, and must be
// issued only while the block is idle.
// ----------------------------------------------------------------------------
module poly_voice_allocator_envelope_top #(
  parameter int VOICE_SLOTS    = pva_pkg::VOICE_SLOTS_DEF,
  parameter int FREQ_FRAC_BITS = pva_pkg::FREQ_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pva_in_if.sink    in_ch,
  pva_out_if.source out_ch,
  pva_cfg_if.sink   cfg_ch
);

  pva_pkg::cmd_t q_data;
  logic          q_valid;
  logic          q_pop;

  pva_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  pva_back #(
    .VOICE_SLOTS    (VOICE_SLOTS),
    .FREQ_FRAC_BITS (FREQ_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch)
  );

endmodule

// File: rtl/core/pva_ram.sv
// ----------------------------------------------------------------------------
// pva_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// File: rtl/core/pva_front.sv
// ----------------------------------------------------------------------------
// pva_front
// Request front end: accepts words, classifies the request code and holds
// the commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module pva_front (
  input  logic             clk,
  input  logic             rst_n,
  pva_in_if.sink           in_ch,
  output pva_pkg::cmd_t    q_data,
  output logic             q_valid,
  input  logic             q_pop
);

  localparam int QD  = pva_pkg::QUEUE_DEPTH;
  localparam int QPW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  pva_pkg::cmd_t  cmd_in;
  pva_pkg::cmd_t  buf_r [QD];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] rd_ptr_r;
  logic [QCW-1:0] cnt_r;
  logic           push;
  logic           pop;

  // Classify the request code
  always_comb begin
    cmd_in.note = in_ch.data.note_number;
    cmd_in.vel  = in_ch.data.note_velocity;
    cmd_in.chan = in_ch.data.midi_channel;
    cmd_in.gain = in_ch.data.bend_gain;
    case (in_ch.data.req_type)
      pva_pkg::REQ_NOTE_ON:   cmd_in.op = pva_pkg::OP_NOTE_ON;
      pva_pkg::REQ_NOTE_OFF:  cmd_in.op = pva_pkg::OP_NOTE_OFF;
      pva_pkg::REQ_BEND:      cmd_in.op = pva_pkg::OP_BEND;
      pva_pkg::REQ_RESET_ALL: cmd_in.op = pva_pkg::OP_CLEAR;
      pva_pkg::REQ_TICK:      cmd_in.op = pva_pkg::OP_TICK;
      default:                cmd_in.op = pva_pkg::OP_NONE;
    endcase
  end

  assign in_ch.ready = (cnt_r != QCW'(QD));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_data      = buf_r[rd_ptr_r];

  // Store the classified word
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= cmd_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPW'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPW'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/pva_back.sv
// ----------------------------------------------------------------------------
// pva_back
// Voice back end: holds the slot table and configuration, walks the slots
// one at a time for note, bend and tick commands and registers the result word.
// ----------------------------------------------------------------------------
module pva_back #(
  parameter int VOICE_SLOTS    = pva_pkg::VOICE_SLOTS_DEF,
  parameter int FREQ_FRAC_BITS = pva_pkg::FREQ_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pva_pkg::cmd_t q_data,
  input  logic          q_valid,
  output logic          q_pop,
  pva_out_if.source     out_ch,
  pva_cfg_if.sink       cfg_ch
);

  localparam int IDX_W = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam int CNT_W = $clog2(VOICE_SLOTS + 1);
  localparam int FW    = pva_pkg::FREQ_INT_W + FREQ_FRAC_BITS;
  localparam int BP_W  = FW + pva_pkg::GAIN_W;
  localparam int AW    = pva_pkg::AMP_W;

  localparam pva_pkg::freq_tab_t  FREQ_TAB  = pva_pkg::build_freq_tab(FREQ_FRAC_BITS);
  localparam pva_pkg::level_tab_t LEVEL_TAB = pva_pkg::build_level_tab();
  localparam logic [FW-1:0]       FREQ_MAX  = {FW{1'b1}};

  typedef struct packed {
    logic [pva_pkg::NOTE_W-1:0] note;
    logic [pva_pkg::CHAN_W-1:0] chan;
    logic [pva_pkg::VEL_W-1:0]  vel;
    logic [FW-1:0]              freq;
    logic [AW-1:0]              amp;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  pva_pkg::bstate_t state_r, state_nxt;
  pva_pkg::cmd_t    cmd_r;
  logic [IDX_W-1:0] idx_r;
  logic [VOICE_SLOTS-1:0] active_r;
  logic [VOICE_SLOTS-1:0] ampv_r;
  logic [CNT_W-1:0] count_r;
  logic             hit_r;
  logic [FW-1:0]    hit_freq_r;
  logic [pva_pkg::CFG_W-1:0] attack_r, decay_r, sustain_r, release_r;
  logic             out_valid_r;
  pva_pkg::out_item_t out_data_r;
  logic [BP_W-1:0]  bprod_r;
  logic [31:0]      rprod_r;
  logic [30:0]      tprod_r;
  logic [AW-1:0]    level_r;

  // Sequencer controls
  logic             last;
  logic             out_free;
  logic             ram_we, ram_re;
  slot_t            ram_wdata;
  logic [SLOT_W-1:0] ram_rdata;
  slot_t            rd_word;
  logic             take, release_hit, clr_all, set_ampv, idx_adv, mul_en, load_out;
  logic             chan_match, slot_match;
  logic [AW-1:0]    amp_eff;
  logic [FW-1:0]    new_freq;
  logic [AW-1:0]    rel_keep;
  logic [32:0]      rel_sum;
  logic [17:0]      rel_amp;
  logic [31:0]      tgt_sum;
  logic [16:0]      target;
  logic [AW:0]      att_sum;
  logic [AW-1:0]    new_amp;
  logic [BP_W:0]    bsum;
  logic [BP_W:0]    bshift;
  logic [FW-1:0]    bend_freq;
  logic [31:0]      cnt_ext;
  logic [31:0]      idx_ext;
  logic [31:0]      freq_ext;

  assign rd_word    = slot_t'(ram_rdata);
  assign last       = (idx_r == IDX_W'(VOICE_SLOTS - 1));
  assign out_free   = !out_valid_r || out_ch.ready;
  assign chan_match = active_r[idx_r] && (rd_word.chan == cmd_r.chan);
  assign slot_match = chan_match && (rd_word.note == cmd_r.note);
  assign amp_eff    = ampv_r[idx_r] ? rd_word.amp : '0;
  assign new_freq   = FREQ_TAB[cmd_r.note][FW-1:0];
  assign rel_keep   = AW'(17'd32768 - {2'b00, release_r});

  // Release, attack and decay of the slot amplitude
  always_comb begin
    rel_sum = {1'b0, rprod_r} + 33'd16384;
    rel_amp = rel_sum[32:15];
    tgt_sum = {1'b0, tprod_r} + 32'd16384;
    target  = tgt_sum[31:15];
    att_sum = {1'b0, amp_eff} + (AW + 1)'(attack_r);
    new_amp = amp_eff;
    if (!active_r[idx_r]) begin
      new_amp = (rel_amp < 18'(pva_pkg::SNAP_LIMIT)) ? '0 : rel_amp[AW-1:0];
    end else if (amp_eff < level_r) begin
      new_amp = att_sum[AW-1:0];
    end else if ({1'b0, amp_eff} > target) begin
      new_amp = (amp_eff > AW'(decay_r)) ? amp_eff - AW'(decay_r) : '0;
    end
  end

  // Bent frequency, rounded and saturated
  always_comb begin
    bsum      = {1'b0, bprod_r} + (BP_W + 1)'(8192);
    bshift    = bsum >> pva_pkg::GAIN_FRAC;
    bend_freq = (bshift > (BP_W + 1)'(FREQ_MAX)) ? FREQ_MAX : bshift[FW-1:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pva_pkg::B_IDLE: begin
        if (q_valid) state_nxt = pva_pkg::B_SCAN;
      end
      pva_pkg::B_SCAN: begin
        case (cmd_r.op)
          pva_pkg::OP_CLEAR, pva_pkg::OP_NONE: state_nxt = pva_pkg::B_OUT;
          pva_pkg::OP_NOTE_ON: begin
            if (!active_r[idx_r] || last) state_nxt = pva_pkg::B_OUT;
          end
          default: state_nxt = pva_pkg::B_CALC;
        endcase
      end
      pva_pkg::B_CALC: begin
        case (cmd_r.op)
          pva_pkg::OP_NOTE_OFF: begin
            if (slot_match || last) state_nxt = pva_pkg::B_OUT;
            else state_nxt = pva_pkg::B_SCAN;
          end
          pva_pkg::OP_BEND: begin
            if (chan_match) state_nxt = pva_pkg::B_WR;
            else if (last) state_nxt = pva_pkg::B_OUT;
            else state_nxt = pva_pkg::B_SCAN;
          end
          pva_pkg::OP_TICK: state_nxt = pva_pkg::B_WR;
          default: state_nxt = pva_pkg::B_OUT;
        endcase
      end
      pva_pkg::B_WR: begin
        state_nxt = last ? pva_pkg::B_OUT : pva_pkg::B_SCAN;
      end
      pva_pkg::B_OUT: begin
        if (out_free) state_nxt = pva_pkg::B_IDLE;
      end
      default: state_nxt = pva_pkg::B_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = rd_word;
    take        = 1'b0;
    release_hit = 1'b0;
    clr_all     = 1'b0;
    set_ampv    = 1'b0;
    idx_adv     = 1'b0;
    mul_en      = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      pva_pkg::B_IDLE: q_pop = q_valid;
      pva_pkg::B_SCAN: begin
        case (cmd_r.op)
          pva_pkg::OP_CLEAR: clr_all = 1'b1;
          pva_pkg::OP_NONE:  ;
          pva_pkg::OP_NOTE_ON: begin
            if (!active_r[idx_r]) begin
              ram_we         = 1'b1;
              ram_wdata.note = cmd_r.note;
              ram_wdata.chan = cmd_r.chan;
              ram_wdata.vel  = cmd_r.vel;
              ram_wdata.freq = new_freq;
              ram_wdata.amp  = '0;
              take           = 1'b1;
            end else begin
              idx_adv = !last;
            end
          end
          default: ram_re = 1'b1;
        endcase
      end
      pva_pkg::B_CALC: begin
        case (cmd_r.op)
          pva_pkg::OP_NOTE_OFF: begin
            if (slot_match) release_hit = 1'b1;
            else idx_adv = !last;
          end
          pva_pkg::OP_BEND: begin
            if (chan_match) mul_en = 1'b1;
            else idx_adv = !last;
          end
          pva_pkg::OP_TICK: mul_en = 1'b1;
          default: ;
        endcase
      end
      pva_pkg::B_WR: begin
        ram_we  = 1'b1;
        idx_adv = !last;
        if (cmd_r.op == pva_pkg::OP_BEND) begin
          ram_wdata.freq = bend_freq;
        end else begin
          ram_wdata.amp = new_amp;
          set_ampv      = 1'b1;
        end
      end
      pva_pkg::B_OUT: load_out = out_free;
      default: ;
    endcase
  end

  pva_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (VOICE_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (idx_r),
    .wr_data (SLOT_W'(ram_wdata)),
    .rd_en   (ram_re),
    .rd_addr (idx_r),
    .rd_data (ram_rdata)
  );

  // Control state: sequencer, slot activity, count, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pva_pkg::B_IDLE;
      idx_r       <= '0;
      active_r    <= '0;
      ampv_r      <= '0;
      count_r     <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        idx_r <= '0;
        hit_r <= 1'b0;
      end else if (idx_adv) begin
        idx_r <= idx_r + 1'b1;
      end
      if (clr_all) begin
        active_r <= '0;
        ampv_r   <= '0;
        count_r  <= '0;
      end
      if (take) begin
        active_r[idx_r] <= 1'b1;
        ampv_r[idx_r]   <= 1'b1;
        count_r         <= count_r + 1'b1;
        hit_r           <= 1'b1;
      end
      if (release_hit) begin
        active_r[idx_r] <= 1'b0;
        count_r         <= count_r - 1'b1;
        hit_r           <= 1'b1;
      end
      if (set_ampv) begin
        ampv_r[idx_r] <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= pva_pkg::ATTACK_RST;
      decay_r   <= pva_pkg::DECAY_RST;
      sustain_r <= pva_pkg::SUSTAIN_RST;
      release_r <= pva_pkg::RELEASE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        pva_pkg::CFG_ATTACK:  attack_r  <= cfg_ch.data.value;
        pva_pkg::CFG_DECAY:   decay_r   <= cfg_ch.data.value;
        pva_pkg::CFG_SUSTAIN: sustain_r <= cfg_ch.data.value;
        pva_pkg::CFG_RELEASE: release_r <= cfg_ch.data.value;
        default: ;
      endcase
    end
  end

  // Hold the command, products and result payload
  assign cnt_ext  = 32'(count_r);
  assign idx_ext  = 32'(idx_r);
  assign freq_ext = 32'(hit_freq_r);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_data;
    end
    if (take) begin
      hit_freq_r <= new_freq;
    end
    if (mul_en) begin
      bprod_r <= BP_W'(rd_word.freq) * BP_W'(cmd_r.gain);
      rprod_r <= 32'(amp_eff) * 32'(rel_keep);
      tprod_r <= 31'(LEVEL_TAB[rd_word.vel]) * 31'(sustain_r);
      level_r <= LEVEL_TAB[rd_word.vel];
    end
    if (load_out) begin
      out_data_r.hit          <= hit_r;
      out_data_r.slot_index   <= hit_r ? idx_ext[pva_pkg::IDX_OUT_W-1:0] : '0;
      out_data_r.slot_freq    <= (hit_r && cmd_r.op == pva_pkg::OP_NOTE_ON) ?
                                 freq_ext[pva_pkg::FREQ_OUT_W-1:0] : '0;
      out_data_r.active_count <= cnt_ext[pva_pkg::COUNT_OUT_W-1:0];
      out_data_r.any_active   <= (count_r != '0);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// File: dv/pva_scoreboard.sv
// ----------------------------------------------------------------------------
// Voice allocator scoreboard
// Tracks the slot table, computes the result word due for each accepted
// request and compares the words that come out of the block against it.
// ----------------------------------------------------------------------------
package pva_tb_pkg;
  import pva_pkg::*;

  class voice_table_model;
    bit              active [16];
    bit [6:0]        note   [16];
    bit [3:0]        chan   [16];
    bit [6:0]        vel    [16];
    bit [23:0]       freq   [16];
    bit [15:0]       amp    [16];
    bit              flag;
    bit [14:0]       attack, decay, sustain, release_f;
    out_item_t       due_words[$];
    int              errors;

    function new();
      attack = ATTACK_RST; decay = DECAY_RST;
      sustain = SUSTAIN_RST; release_f = RELEASE_RST;
      flag = 0; errors = 0;
      foreach (active[i]) begin
        active[i] = 0; note[i] = 0; chan[i] = 0; vel[i] = 0; freq[i] = 0; amp[i] = 0;
      end
    endfunction

    function void write_reg(cfg_idx_t idx, bit [14:0] v);
      case (idx)
        CFG_ATTACK:  attack = v;
        CFG_DECAY:   decay = v;
        CFG_SUSTAIN: sustain = v;
        CFG_RELEASE: release_f = v;
        default: ;
      endcase
    endfunction

    // Equal-tempered pitch, Q16.8, rounded half up
    function bit [23:0] pitch(bit [6:0] n);
      longint unsigned v;
      int sh;
      sh = (10 - n / 12) + 8;
      v = TOP_OCTAVE[n % 12];
      v = (v + (64'd1 << (sh - 1))) >> sh;
      return v[23:0];
    endfunction

    function int voices();
      int c;
      c = 0;
      foreach (active[i]) if (active[i]) c++;
      return c;
    endfunction

    // Advance one voice through attack/decay or release
    function void tick_voice(int i);
      longint unsigned a, level, target;
      a = amp[i];
      if (!active[i]) begin
        a = (a * (32768 - release_f) + 16384) >> 15;
        if (a < SNAP_LIMIT) a = 0;
      end else begin
        level = (vel[i] * 32768 + 63) / 127;
        target = (level * sustain + 16384) >> 15;
        if (a < level) a = a + attack;
        else if (a > target) a = (a > decay) ? a - decay : 0;
      end
      amp[i] = a[15:0];
    endfunction

    // Note an accepted request and queue the word it is due to produce
    function void note_request(in_item_t r);
      out_item_t w;
      longint unsigned f;
      w = '0;
      case (r.req_type)
        REQ_NOTE_ON: begin
          for (int i = 0; i < 16; i++) begin
            if (!active[i]) begin
              w.slot_freq = pitch(r.note_number);
              freq[i] = w.slot_freq; vel[i] = r.note_velocity; amp[i] = 0;
              active[i] = 1; note[i] = r.note_number; chan[i] = r.midi_channel;
              flag = 1; w.hit = 1; w.slot_index = i;
              break;
            end
          end
        end
        REQ_NOTE_OFF: begin
          for (int i = 0; i < 16; i++) begin
            if (active[i] && note[i] == r.note_number && chan[i] == r.midi_channel) begin
              active[i] = 0; w.hit = 1; w.slot_index = i;
              break;
            end
          end
          flag = voices() != 0;
        end
        REQ_BEND: begin
          foreach (active[i]) begin
            if (active[i] && chan[i] == r.midi_channel) begin
              f = (longint'(freq[i]) * r.bend_gain + 8192) >> 14;
              if (f > 24'hFFFFFF) f = 24'hFFFFFF;
              freq[i] = f[23:0];
            end
          end
        end
        REQ_RESET_ALL: begin
          foreach (active[i]) begin
            active[i] = 0; amp[i] = 0;
          end
          flag = 0;
        end
        REQ_TICK: for (int i = 0; i < 16; i++) tick_voice(i);
        default: ;
      endcase
      w.active_count = voices();
      w.any_active = flag;
      due_words.push_back(w);
    endfunction

    // Compare one result word with the oldest one due
    function void check_result(out_item_t got);
      out_item_t e;
      if (due_words.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      e = due_words.pop_front();
      if (got.hit !== e.hit) begin
        $error("hit: expected %0d, actual %0d", e.hit, got.hit); errors++;
      end
      if (got.slot_index !== e.slot_index) begin
        $error("slot_index: expected %0d, actual %0d", e.slot_index, got.slot_index);
        errors++;
      end
      if (got.slot_freq !== e.slot_freq) begin
        $error("slot_freq: expected %0d, actual %0d", e.slot_freq, got.slot_freq); errors++;
      end
      if (got.active_count !== e.active_count) begin
        $error("active_count: expected %0d, actual %0d", e.active_count, got.active_count);
        errors++;
      end
      if (got.any_active !== e.any_active) begin
        $error("any_active: expected %0d, actual %0d", e.any_active, got.any_active);
        errors++;
      end
    endfunction
  endclass
endpackage

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Drives note-on/off, bend, reset-all and envelope-tick words through the
// valid/ready channels with random gaps and stalls, changes the envelope
// registers between phases and checks every result word in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pva_pkg::*;
  import pva_tb_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  bit   out_stall_on = 0;
  int   stall_left = 0;
  voice_table_model voice_tbl;

  pva_in_if  in_ch();
  pva_out_if out_ch();
  pva_cfg_if cfg_ch();

  poly_voice_allocator_envelope_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one request word and hold it until taken; valid stays high for
  // back-to-back words and drops only for a gap
  task automatic send_word(in_item_t w);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    voice_tbl.note_request(w);
  endtask

  // Write one register; valid is dropped by the caller after the last write
  task automatic write_reg(cfg_idx_t idx, logic [14:0] v);
    cfg_item_t c;
    c.index = idx;
    c.value = v;
    cfg_ch.valid <= 1;
    cfg_ch.data  <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    voice_tbl.write_reg(idx, v);
  endtask

  // Drop the request, wait for all due words, then let the back end settle
  task automatic drain();
    in_ch.valid <= 0;
    while (voice_tbl.due_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_req(req_t t, int n, int v, int ch, int g);
    in_item_t w;
    w.req_type = t;
    w.note_number = n;
    w.note_velocity = v;
    w.midi_channel = ch;
    w.bend_gain = g;
    send_word(w);
  endtask

  // Random request with a bias towards well-formed note sequences
  task automatic send_random(int hold_notes);
    int r;
    in_item_t w;
    w = in_item_t'({$urandom, $urandom});
    r = $urandom_range(99);
    if (r < 35) w.req_type = REQ_NOTE_ON;
    else if (r < 60) w.req_type = REQ_NOTE_OFF;
    else if (r < 70) w.req_type = REQ_BEND;
    else if (r < 72) w.req_type = REQ_RESET_ALL;
    else if (r < 97) w.req_type = REQ_TICK;
    else w.req_type = $urandom_range(5, 7);
    // keep notes in a small pool so note-offs find their voice
    if (hold_notes) begin
      w.note_number = $urandom_range(60, 63);
      w.midi_channel = $urandom_range(0, 2);
    end
    if (w.req_type == REQ_BEND && $urandom_range(3) != 0)
      w.bend_gain = $urandom_range(14000, 19000);
    send_word(w);
  endtask

  // Collect result words with random stalls, mostly short and a few long
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) voice_tbl.check_result(out_ch.data);
    if (!out_stall_on) begin
      out_ch.ready <= 1;
    end else if (stall_left > 0) begin
      out_ch.ready <= 0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(99) < 3) begin
      out_ch.ready <= 0;
      stall_left   <= $urandom_range(10, 60);
    end else begin
      out_ch.ready <= ($urandom_range(9) < 6);
    end
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    voice_tbl = new();
    in_ch.valid = 0; in_ch.data = '0;
    cfg_ch.valid = 0; cfg_ch.data = '0;
    out_ch.ready = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: field extremes, every request, full table and misses
    send_req(REQ_NOTE_OFF, 5, 0, 0, 0);
    send_req(REQ_NOTE_ON, 0, 0, 0, 0);
    send_req(REQ_NOTE_ON, 127, 127, 15, 0);
    for (int i = 0; i < 15; i++) send_req(REQ_NOTE_ON, 60 + i, 127 - i, i, 0);
    send_req(REQ_TICK, 0, 0, 0, 0);
    send_req(REQ_BEND, 0, 0, 15, 16'hFFFF);
    send_req(REQ_BEND, 0, 0, 0, 0);
    send_req(REQ_NOTE_OFF, 127, 0, 15, 0);
    send_req(REQ_TICK, 0, 0, 0, 0);
    send_req(req_t'(3'd7), 127, 127, 15, 16'hFFFF);
    send_req(REQ_RESET_ALL, 0, 0, 0, 0);
    send_req(REQ_TICK, 0, 0, 0, 0);
    drain();

    // Random phases across register settings, extremes included
    out_stall_on = 1;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;
        1: begin
          write_reg(CFG_ATTACK, 15'h7FFF); write_reg(CFG_DECAY, 15'h7FFF);
          write_reg(CFG_SUSTAIN, 0); write_reg(CFG_RELEASE, 15'h7FFF);
        end
        2: begin
          write_reg(CFG_ATTACK, 0); write_reg(CFG_DECAY, 0);
          write_reg(CFG_SUSTAIN, 15'h7FFF); write_reg(CFG_RELEASE, 0);
        end
        default: begin
          write_reg(CFG_ATTACK, $urandom_range(1, 32767));
          write_reg(CFG_DECAY, $urandom_range(1, 32767));
          write_reg(CFG_SUSTAIN, $urandom_range(32767));
          write_reg(CFG_RELEASE, $urandom_range(32767));
        end
      endcase
      cfg_ch.valid <= 0;
      out_stall_on = (ph != 3);
      for (int k = 0; k < 240; k++) send_random($urandom_range(9) < 7);
      drain();
    end

    if (voice_tbl.errors == 0 && voice_tbl.due_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/pva_pkg.sv
rtl/core/pva_if.sv
rtl/core/pva_ram.sv
rtl/core/pva_front.sv
rtl/core/pva_back.sv
rtl/core/poly_voice_allocator_envelope_top.sv
dv/pva_scoreboard.sv
dv/tb.sv
